// ----- sv/twnl_pkg.sv -----
// shared types, constants and helpers for the two-wire nibble link
package twnl_pkg;

    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NIB_W    = 4;
    localparam int FRAME_W  = 2 * NIB_W;
    localparam int BIT_IDX_W = 3;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SAMPLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACK          = 3'd5;

    // register reset values
    localparam logic [TICK_W-1:0] RST_START_LOW    = 16'd20;
    localparam logic [TICK_W-1:0] RST_BIT          = 16'd5;
    localparam logic [TICK_W-1:0] RST_STOP_HIGH    = 16'd15;
    localparam logic [TICK_W-1:0] RST_CONFIRM      = 16'd2;
    localparam logic [TICK_W-1:0] RST_FIRST_SAMPLE = 16'd19;
    localparam logic [TICK_W-1:0] RST_ACK          = 16'd20;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    typedef enum logic [8:0] {
        PH_IDLE       = 9'b000000001,
        PH_TX_START   = 9'b000000010,
        PH_TX_BITS    = 9'b000000100,
        PH_TX_STOP    = 9'b000001000,
        PH_TX_WAIT    = 9'b000010000,
        PH_RX_CONFIRM = 9'b000100000,
        PH_RX_FIRST   = 9'b001000000,
        PH_RX_BITS    = 9'b010000000,
        PH_ACK        = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] start_low_ticks;
        logic [TICK_W-1:0] bit_ticks;
        logic [TICK_W-1:0] stop_high_ticks;
        logic [TICK_W-1:0] confirm_ticks;
        logic [TICK_W-1:0] first_sample_ticks;
        logic [TICK_W-1:0] ack_ticks;
    } cfg_t;

    typedef struct packed {
        logic             busy_res;
        logic             send_ok;
        logic             send_done;
        logic [NIB_W-1:0] rx_value;
        logic             rx_valid;
        logic             line_drive;
    } res_t;

    // ticks left after the first tick of a phase; zero counts as one
    function automatic logic [TICK_W-1:0] left_after_first(input logic [TICK_W-1:0] d);
        left_after_first = (d == '0) ? '0 : d - 1'b1;
    endfunction

endpackage

// ----- sv/twnl_cfg.sv -----
// configuration register bank of the nibble link
module twnl_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [twnl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [twnl_pkg::TICK_W-1:0]    cfg_data,
    output twnl_pkg::cfg_t                 cfg
);
    import twnl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks    <= RST_START_LOW;
            cfg_reg.bit_ticks          <= RST_BIT;
            cfg_reg.stop_high_ticks    <= RST_STOP_HIGH;
            cfg_reg.confirm_ticks      <= RST_CONFIRM;
            cfg_reg.first_sample_ticks <= RST_FIRST_SAMPLE;
            cfg_reg.ack_ticks          <= RST_ACK;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_LOW:    cfg_reg.start_low_ticks    <= cfg_data;
                REG_BIT:          cfg_reg.bit_ticks          <= cfg_data;
                REG_STOP_HIGH:    cfg_reg.stop_high_ticks    <= cfg_data;
                REG_CONFIRM:      cfg_reg.confirm_ticks      <= cfg_data;
                REG_FIRST_SAMPLE: cfg_reg.first_sample_ticks <= cfg_data;
                REG_ACK:          cfg_reg.ack_ticks          <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/twnl_fsm.sv -----
// link sequencer: phase, tick counter and frame shifter, one tick per step
module twnl_fsm (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       req_type,
    input  logic [twnl_pkg::NIB_W-1:0] send_value,
    input  logic                       peer_level,
    input  twnl_pkg::cfg_t             cfg,
    output twnl_pkg::res_t             res
);
    import twnl_pkg::*;

    phase_t                 phase_reg,  phase_next;
    logic [TICK_W-1:0]      tick_reg,   tick_next;
    logic [BIT_IDX_W-1:0]   bit_reg,    bit_next;
    logic [FRAME_W-1:0]     frame_reg,  frame_next;
    logic                   drive_reg,  drive_next;
    logic                   sd, sok, rxv;
    logic [NIB_W-1:0]       rxval;
    logic [BIT_IDX_W-1:0]   tx_pos;

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        frame_next = frame_reg;
        drive_next = drive_reg;
        sd    = 1'b0;
        sok   = 1'b0;
        rxv   = 1'b0;
        rxval = '0;
        tx_pos = '0;

        if (phase_reg == PH_IDLE) begin
            if (req_type && peer_level) begin
                frame_next = {send_value, send_value};
                bit_next   = '0;
                phase_next = PH_TX_START;
                tick_next  = left_after_first(cfg.start_low_ticks);
                drive_next = 1'b0;
            end else if (req_type) begin
                // peer is talking: refuse and listen
                sd = 1'b1;
            end
            if (!peer_level) begin
                phase_next = PH_RX_CONFIRM;
                tick_next  = left_after_first(cfg.confirm_ticks);
                drive_next = 1'b1;
            end
        end else if (phase_reg == PH_TX_WAIT) begin
            if (peer_level) begin
                sd = 1'b1;
                sok = 1'b1;
                phase_next = PH_IDLE;
                tick_next  = '0;
                drive_next = 1'b1;
            end
        end else if (tick_reg != '0) begin
            tick_next = tick_reg - 1'b1;
        end else begin
            unique case (phase_reg)
                PH_TX_START: begin
                    bit_next   = '0;
                    phase_next = PH_TX_BITS;
                    tick_next  = left_after_first(cfg.bit_ticks);
                    drive_next = frame_reg[FRAME_W-1];
                end
                PH_TX_BITS: begin
                    if (bit_reg == LAST_BIT) begin
                        phase_next = PH_TX_STOP;
                        tick_next  = left_after_first(cfg.stop_high_ticks);
                        drive_next = 1'b1;
                    end else begin
                        bit_next   = bit_reg + 1'b1;
                        tx_pos     = LAST_BIT - bit_next;
                        tick_next  = left_after_first(cfg.bit_ticks);
                        drive_next = frame_reg[tx_pos];
                    end
                end
                PH_TX_STOP: begin
                    drive_next = 1'b1;
                    tick_next  = '0;
                    if (!peer_level) begin
                        phase_next = PH_TX_WAIT;
                    end else begin
                        sd = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_RX_CONFIRM: begin
                    drive_next = 1'b1;
                    if (!peer_level) begin
                        phase_next = PH_RX_FIRST;
                        tick_next  = left_after_first(cfg.first_sample_ticks);
                    end else begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                end
                PH_RX_FIRST: begin
                    bit_next   = '0;
                    frame_next = {{(FRAME_W-1){1'b0}}, peer_level};
                    phase_next = PH_RX_BITS;
                    tick_next  = left_after_first(cfg.bit_ticks);
                    drive_next = 1'b1;
                end
                PH_RX_BITS: begin
                    if (bit_reg == LAST_BIT) begin
                        if (frame_reg[FRAME_W-1:NIB_W] == frame_reg[NIB_W-1:0] &&
                            frame_reg[FRAME_W-1:NIB_W] != '0) begin
                            rxv        = 1'b1;
                            rxval      = frame_reg[FRAME_W-1:NIB_W];
                            phase_next = PH_ACK;
                            tick_next  = left_after_first(cfg.ack_ticks);
                            drive_next = 1'b0;
                        end else begin
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                            drive_next = 1'b1;
                        end
                    end else begin
                        bit_next   = bit_reg + 1'b1;
                        frame_next = {frame_reg[FRAME_W-2:0], peer_level};
                        tick_next  = left_after_first(cfg.bit_ticks);
                        drive_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    drive_next = 1'b1;
                end
            endcase
        end

        // request arriving while busy is refused unless a send just finished
        if (phase_reg != PH_IDLE && req_type && !sd) begin
            sd  = 1'b1;
            sok = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            frame_reg <= '0;
            drive_reg <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            frame_reg <= frame_next;
            drive_reg <= drive_next;
        end
    end

    always_comb begin
        res.line_drive = drive_next;
        res.rx_valid   = rxv;
        res.rx_value   = rxval;
        res.send_done  = sd;
        res.send_ok    = sok;
        res.busy_res   = (phase_next != PH_IDLE);
    end

endmodule

// ----- sv/two_wire_nibble_link.sv -----
// top level of the two-wire nibble link: stream ports, tick register, result register
//
// each input transfer is one timing tick carrying the sampled peer line and an
// optional send request; each tick gives exactly one result transfer. a tick
// passes through an input register, the sequencer logic and a result register,
// and one tick is taken every cycle while the result side keeps up; a stalled
// result register holds the tick register and then the input side. configuration
// is a plain write port (indexes 0..5 as listed in the package, others ignored);
// it must be written only while the link is quiet; the block does not enforce it.
module two_wire_nibble_link (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [twnl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twnl_pkg::TICK_W-1:0]     cfg_data,
    // tick input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [twnl_pkg::S_DATA_W-1:0]   s_tdata,  // send_value[3:0], peer_level[4]
    input  logic                            s_tuser,  // req_type
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_drive[0], rx_valid[1], rx_value[5:2], send_done[6], send_ok[7], busy_res[8]
    output logic [twnl_pkg::M_DATA_W-1:0]   m_tdata
);
    import twnl_pkg::*;

    localparam int RES_W = $bits(res_t);

    cfg_t cfg;
    res_t res;

    // tick register
    logic             in_valid_reg;
    logic             in_req_reg;
    logic [NIB_W-1:0] in_val_reg;
    logic             in_peer_reg;

    // result register
    logic             out_valid_reg;
    res_t             out_res_reg;

    logic advance;
    logic step;

    // result register free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    twnl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    twnl_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .req_type   (in_req_reg),
        .send_value (in_val_reg),
        .peer_level (in_peer_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg  <= s_tuser;
            in_val_reg  <= s_tdata[NIB_W-1:0];
            in_peer_reg <= s_tdata[NIB_W];
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-RES_W){1'b0}}, out_res_reg};

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the two-wire nibble link: tick stream in, result stream out
module tb;
    import twnl_pkg::*;

    // one timing tick as carried on the input stream
    typedef struct packed {
        logic             req;
        logic [NIB_W-1:0] value;
        logic             peer;
    } tick_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TICK_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;  // send_value[3:0], peer_level[4]
    logic                  s_tuser = 1'b0;  // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // line_drive[0], rx_valid[1], rx_value[5:2], send_done[6], send_ok[7], busy_res[8]
    logic [M_DATA_W-1:0]   m_tdata;

    // predicted link state, advanced once per tick in the order the ticks are sent
    phase_t                link_phase = PH_IDLE;
    logic [TICK_W-1:0]     link_left = '0;
    logic [BIT_IDX_W-1:0]  link_bit = '0;
    logic [FRAME_W-1:0]    link_frame = '0;
    logic                  link_drive = 1'b1;
    cfg_t                  link_cfg;

    // results still owed by the link, oldest first
    res_t                  due_results[$];

    // the simulated peer: scripted line levels for a frame it sends, and how
    // long it keeps its acknowledge low
    logic                  peer_script[$];
    int unsigned           ack_hold = 0;

    int unsigned           src_idle_pct = 0;
    int unsigned           sink_stall_pct = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           results_seen = 0;

    always #1 aclk = ~aclk;

    two_wire_nibble_link DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------
    // link predictor
    // ---------------------------------------------------------------

    // a phase of length d lasts d ticks including the one that enters it; zero acts as one
    function automatic void enter_phase(input phase_t ph, input logic [TICK_W-1:0] d,
                                        input logic level);
        link_phase = ph;
        link_left  = (d == '0) ? '0 : d - 16'd1;
        link_drive = level;
    endfunction

    function automatic res_t predict_tick(input tick_t t);
        res_t r;
        logic was_idle;
        r = '0;
        was_idle = (link_phase == PH_IDLE);
        if (was_idle) begin
            if (t.req) begin
                if (t.peer) begin
                    link_frame = {t.value, t.value};
                    link_bit   = '0;
                    enter_phase(PH_TX_START, link_cfg.start_low_ticks, 1'b0);
                end else begin
                    // peer is talking: refuse, reception starts below
                    r.send_done = 1'b1;
                end
            end
            if (link_phase == PH_IDLE && !t.peer)
                enter_phase(PH_RX_CONFIRM, link_cfg.confirm_ticks, 1'b1);
        end else if (link_phase == PH_TX_WAIT) begin
            if (t.peer) begin
                r.send_done = 1'b1;
                r.send_ok   = 1'b1;
                enter_phase(PH_IDLE, 16'd1, 1'b1);
            end
        end else if (link_left != '0) begin
            link_left = link_left - 16'd1;
        end else begin
            case (link_phase)
                PH_TX_START: begin
                    link_bit = '0;
                    enter_phase(PH_TX_BITS, link_cfg.bit_ticks, link_frame[LAST_BIT - link_bit]);
                end
                PH_TX_BITS: begin
                    if (link_bit == LAST_BIT) begin
                        enter_phase(PH_TX_STOP, link_cfg.stop_high_ticks, 1'b1);
                    end else begin
                        link_bit = link_bit + 1'b1;
                        enter_phase(PH_TX_BITS, link_cfg.bit_ticks,
                                    link_frame[LAST_BIT - link_bit]);
                    end
                end
                PH_TX_STOP: begin
                    if (!t.peer) begin
                        enter_phase(PH_TX_WAIT, 16'd1, 1'b1);
                    end else begin
                        r.send_done = 1'b1;
                        enter_phase(PH_IDLE, 16'd1, 1'b1);
                    end
                end
                PH_RX_CONFIRM: begin
                    if (!t.peer)
                        enter_phase(PH_RX_FIRST, link_cfg.first_sample_ticks, 1'b1);
                    else
                        enter_phase(PH_IDLE, 16'd1, 1'b1);
                end
                PH_RX_FIRST: begin
                    link_bit   = '0;
                    link_frame = {7'd0, t.peer};
                    enter_phase(PH_RX_BITS, link_cfg.bit_ticks, 1'b1);
                end
                PH_RX_BITS: begin
                    if (link_bit == LAST_BIT) begin
                        // frame judged: both nibbles equal and nonzero
                        if (link_frame[7:4] == link_frame[3:0] && link_frame[7:4] != '0) begin
                            r.rx_valid = 1'b1;
                            r.rx_value = link_frame[7:4];
                            enter_phase(PH_ACK, link_cfg.ack_ticks, 1'b0);
                        end else begin
                            enter_phase(PH_IDLE, 16'd1, 1'b1);
                        end
                    end else begin
                        link_bit   = link_bit + 1'b1;
                        link_frame = {link_frame[6:0], t.peer};
                        enter_phase(PH_RX_BITS, link_cfg.bit_ticks, 1'b1);
                    end
                end
                default: enter_phase(PH_IDLE, 16'd1, 1'b1);
            endcase
        end
        // a request that finds the link busy is refused unless a send ends on this tick
        if (!was_idle && t.req && !r.send_done)
            r.send_done = 1'b1;
        r.line_drive = link_drive;
        r.busy_res   = (link_phase != PH_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // simulated peer
    // ---------------------------------------------------------------

    function automatic tick_t mk_tick(input logic req, input logic [NIB_W-1:0] value,
                                      input logic peer);
        tick_t t;
        t.req   = req;
        t.value = value;
        t.peer  = peer;
        return t;
    endfunction

    // line levels of a frame sent by the peer, lined up with the link's sample points;
    // with a failed confirm the peer lets go at the recheck and stops there
    function automatic void queue_peer_frame(input logic [FRAME_W-1:0] frame,
                                             input bit fail_confirm);
        int unsigned c, f, b;
        c = (link_cfg.confirm_ticks == '0) ? 1 : link_cfg.confirm_ticks;
        f = (link_cfg.first_sample_ticks == '0) ? 1 : link_cfg.first_sample_ticks;
        b = (link_cfg.bit_ticks == '0) ? 1 : link_cfg.bit_ticks;
        repeat (c) peer_script.push_back(1'b0);
        peer_script.push_back(fail_confirm);
        if (!fail_confirm) begin
            repeat (f - 1) peer_script.push_back(1'b0);
            for (int k = 7; k >= 0; k--)
                repeat (b) peer_script.push_back(frame[k]);
            peer_script.push_back(1'b1);
        end
    endfunction

    // next tick of random traffic: mostly well-formed frames and acknowledged sends,
    // with line noise, bad frames, lost acknowledges and requests at awkward moments
    function automatic tick_t next_random_tick();
        tick_t t;
        logic [FRAME_W-1:0] frame;
        int unsigned pick;
        pick = $urandom_range(99);
        t = mk_tick(1'b0, 4'($urandom), 1'b1);
        if (link_phase == PH_IDLE && peer_script.size() == 0) begin
            if (pick < 25) begin
                case ($urandom_range(9))
                    0:       frame = 8'h00;
                    1, 2:    frame = 8'($urandom);
                    default: frame = {2{4'($urandom_range(1, 15))}};
                endcase
                queue_peer_frame(frame, $urandom_range(9) == 0);
            end else if (pick < 30) begin
                t.peer = 1'b0;  // short glitch, fails the confirm
            end
            t.req = ($urandom_range(99) < 20);
        end else begin
            t.req = ($urandom_range(99) < 4);
            if (link_phase == PH_TX_STOP && link_left == '0) begin
                // ack check on this tick
                if ($urandom_range(99) < 80) begin
                    t.peer   = 1'b0;
                    ack_hold = $urandom_range(0, 5);
                end
            end else if (link_phase == PH_TX_WAIT) begin
                if (ack_hold != 0) begin
                    t.peer   = 1'b0;
                    ack_hold = ack_hold - 1;
                end
            end else begin
                t.peer = ($urandom_range(99) >= 5);
            end
        end
        if (peer_script.size() != 0)
            t.peer = peer_script.pop_front();
        return t;
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // predict one tick, then offer it until the link takes the transfer
    task automatic push_tick(input tick_t t);
        due_results.push_back(predict_tick(t));
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, t.peer, t.value};
        s_tuser  <= t.req;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic play_peer();
        while (peer_script.size() != 0)
            push_tick(mk_tick(1'b0, 4'($urandom), peer_script.pop_front()));
    endtask

    task automatic idle_link();
        while (link_phase != PH_IDLE)
            push_tick(mk_tick(1'b0, 4'($urandom), 1'b1));
    endtask

    // tick through a send with a noisy peer line up to the ack check
    task automatic run_to_ack_check();
        while (!(link_phase == PH_TX_STOP && link_left == '0))
            push_tick(mk_tick(1'b0, 4'($urandom), 1'($urandom)));
    endtask

    // bring the link back to idle and let every owed result come out
    task automatic quiesce();
        peer_script.delete();
        ack_hold = 0;
        idle_link();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
    endtask

    // only called with the link quiet
    task automatic set_timing(input cfg_t c);
        write_reg(REG_START_LOW,    c.start_low_ticks);
        write_reg(REG_BIT,          c.bit_ticks);
        write_reg(REG_STOP_HIGH,    c.stop_high_ticks);
        write_reg(REG_CONFIRM,      c.confirm_ticks);
        write_reg(REG_FIRST_SAMPLE, c.first_sample_ticks);
        write_reg(REG_ACK,          c.ack_ticks);
        cfg_we <= 1'b0;
        link_cfg = c;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset timing: acknowledged send with a noisy peer line, then a good frame in
    task automatic test_reset_timing();
        push_tick(mk_tick(1'b1, 4'hA, 1'b1));
        run_to_ack_check();
        push_tick(mk_tick(1'b0, 4'h0, 1'b0));
        push_tick(mk_tick(1'b0, 4'h0, 1'b0));
        push_tick(mk_tick(1'b0, 4'h0, 1'b1));
        queue_peer_frame(8'h55, 1'b0);
        play_peer();
        quiesce();
    endtask

    // zero durations act as one: zero value sent without ack, bad frames, failed confirm
    task automatic test_zero_timing();
        set_timing(cfg_t'({6{16'd0}}));
        push_tick(mk_tick(1'b1, 4'h0, 1'b1));
        run_to_ack_check();
        push_tick(mk_tick(1'b0, 4'h0, 1'b1));
        queue_peer_frame(8'hF0, 1'b0);   // unequal nibbles
        play_peer();
        idle_link();
        queue_peer_frame(8'h00, 1'b0);   // zero nibbles
        play_peer();
        idle_link();
        queue_peer_frame(8'hEE, 1'b1);   // peer lets go at the recheck
        play_peer();
        queue_peer_frame(8'hEE, 1'b0);
        play_peer();
        quiesce();
    endtask

    // requests against a busy link: mid send, on the send's completion tick,
    // with the peer line low, and during the acknowledge
    task automatic test_busy_requests();
        set_timing(cfg_t'({6{16'd1}}));
        push_tick(mk_tick(1'b1, 4'hF, 1'b1));
        push_tick(mk_tick(1'b1, 4'h3, 1'b1));
        run_to_ack_check();
        push_tick(mk_tick(1'b0, 4'h0, 1'b0));
        push_tick(mk_tick(1'b0, 4'h0, 1'b0));
        push_tick(mk_tick(1'b1, 4'h6, 1'b1));   // completion wins, request dropped
        queue_peer_frame(8'h99, 1'b0);
        push_tick(mk_tick(1'b1, 4'h2, peer_script.pop_front()));
        play_peer();
        push_tick(mk_tick(1'b1, 4'h1, 1'b1));
        queue_peer_frame(8'h11, 1'b0);
        idle_link();
        play_peer();
        quiesce();
    endtask

    // long durations on every counter, short bit time
    task automatic test_long_timing();
        cfg_t c;
        c = cfg_t'({6{16'd40}});
        c.bit_ticks = 16'd3;
        set_timing(c);
        push_tick(mk_tick(1'b1, 4'h9, 1'b1));
        run_to_ack_check();
        push_tick(mk_tick(1'b0, 4'h0, 1'b0));
        push_tick(mk_tick(1'b0, 4'h0, 1'b1));
        queue_peer_frame(8'h77, 1'b0);
        play_peer();
        quiesce();
    endtask

    // random traffic under short random timing with the given idling on each side
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                       input int unsigned n_ticks);
        cfg_t c;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        c.start_low_ticks    = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        c.bit_ticks          = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        c.stop_high_ticks    = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        c.confirm_ticks      = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        c.first_sample_ticks = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        c.ack_ticks          = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        set_timing(c);
        repeat (n_ticks) push_tick(next_random_tick());
        quiesce();
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH %s", msg);
    endtask

    task automatic check_field(input string name, input logic [NIB_W-1:0] got,
                               input logic [NIB_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // each result transfer is checked against the oldest prediction; the receiver
    // stalls at random with the stall percentage set by the current test
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[8:0]);
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with none owed: %h", results_seen, m_tdata));
            end else begin
                want = due_results.pop_front();
                check_field("line_drive", got.line_drive, want.line_drive);
                check_field("rx_valid",   got.rx_valid,   want.rx_valid);
                check_field("rx_value",   got.rx_value,   want.rx_value);
                check_field("send_done",  got.send_done,  want.send_done);
                check_field("send_ok",    got.send_ok,    want.send_ok);
                check_field("busy_res",   got.busy_res,   want.busy_res);
                if (m_tdata[M_DATA_W-1:9] !== '0)
                    report_mismatch($sformatf("result %0d padding not zero: %h",
                                              results_seen, m_tdata));
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial begin
        link_cfg = '{start_low_ticks: RST_START_LOW, bit_ticks: RST_BIT,
                     stop_high_ticks: RST_STOP_HIGH, confirm_ticks: RST_CONFIRM,
                     first_sample_ticks: RST_FIRST_SAMPLE, ack_ticks: RST_ACK};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_timing();
        test_zero_timing();
        test_busy_requests();
        test_long_timing();
        test_random_traffic(0, 0, 160);
        test_random_traffic(82, 0, 160);
        test_random_traffic(0, 82, 160);
        test_random_traffic(30, 30, 160);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial begin
        #60000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
